### rtl/core/pie_list_pkg.sv
package pie_list_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;
    localparam int OR_GROUP      = 8;

    typedef logic [2:0] op_t;

    localparam op_t OP_READ   = 3'd0;
    localparam op_t OP_WRITE  = 3'd1;
    localparam op_t OP_APPEND = 3'd2;
    localparam op_t OP_INSERT = 3'd3;
    localparam op_t OP_ERASE  = 3'd4;

    // command broadcast to every cell
    typedef logic [2:0] kind_t;

    localparam kind_t K_NONE   = 3'd0;
    localparam kind_t K_READ   = 3'd1;
    localparam kind_t K_LOAD   = 3'd2;
    localparam kind_t K_INSERT = 3'd3;
    localparam kind_t K_ERASE  = 3'd4;

    typedef struct packed {
        op_t                op;
        logic        [6:0]  position;
        logic signed [31:0] word_in;
    } in_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] word_out;
        logic        [6:0]  count;
    } out_t;

endpackage

### rtl/core/pie_list_cell.sv
module pie_list_cell #(
    parameter int CAPACITY  = pie_list_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = pie_list_pkg::WORD_BITS_DEF,
    parameter int INDEX     = 0,
    localparam int IDX_W    = $clog2(CAPACITY)
) (
    input  logic                      clk,
    input  pie_list_pkg::kind_t       kind,
    input  logic [IDX_W-1:0]          idx,
    input  logic [WORD_BITS-1:0]      word,
    input  logic [WORD_BITS-1:0]      left,
    input  logic [WORD_BITS-1:0]      right,
    output logic [WORD_BITS-1:0]      value,
    output logic [WORD_BITS-1:0]      sel
);

    localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

    logic [WORD_BITS-1:0] value_reg;
    logic [WORD_BITS-1:0] value_next;
    logic [WORD_BITS-1:0] sel_reg;
    logic [WORD_BITS-1:0] sel_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (kind)
            pie_list_pkg::K_LOAD:
            begin
                if (idx == ME)
                begin
                    value_next = word;
                end
            end
            pie_list_pkg::K_INSERT:
            begin
                // cells above the slot take the left neighbor
                if (ME > idx)
                begin
                    value_next = left;
                end
                else if (ME == idx)
                begin
                    value_next = word;
                end
            end
            pie_list_pkg::K_ERASE:
            begin
                if (ME >= idx)
                begin
                    value_next = right;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // only the addressed cell drives its word toward the or tree
    assign sel_next = (kind == pie_list_pkg::K_READ && idx == ME) ? value_reg : '0;

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        sel_reg   <= sel_next;
    end

    assign value = value_reg;
    assign sel   = sel_reg;

endmodule

### rtl/core/pie_list_or_tree.sv
module pie_list_or_tree #(
    parameter int N        = pie_list_pkg::CAPACITY_DEF,
    parameter int W        = pie_list_pkg::WORD_BITS_DEF,
    parameter int G        = pie_list_pkg::OR_GROUP,
    localparam int NG      = (N + G - 1) / G
) (
    input  logic         clk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] grp  [NG]
);

    logic [W-1:0] grp_reg  [NG];
    logic [W-1:0] grp_next [NG];

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < G; k++)
            begin
                if (g * G + k < N)
                begin
                    grp_next[g] = grp_next[g] | leaf[g * G + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign grp = grp_reg;

endmodule

### rtl/core/positional_insert_erase_list.sv
// Ordered list of up to CAPACITY words held in a row of cells, one word per
// cell. Insert and erase move every later word by one place in the same update,
// each cell taking its left or right neighbor. A request's result is valid once
// it has been registered in order: the accepting edge updates the cells and
// registers the addressed cell's read select, then the group level of the or
// tree is registered, and then the final or goes into the output register. One
// request is in flight at a time, so the block takes no new request until the
// last result has reached the output register and that register is free. Cell
// contents are not cleared at reset; only the count and the valid flags are,
// and no word at or above the count is ever read.
module positional_insert_erase_list #(
    parameter int CAPACITY  = pie_list_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = pie_list_pkg::WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pie_list_pkg::in_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pie_list_pkg::out_t  out_data
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;
    localparam int NG     = (CAPACITY + pie_list_pkg::OR_GROUP - 1) / pie_list_pkg::OR_GROUP;

    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic                 p1_valid_reg;
    logic                 p2_valid_reg;
    logic                 out_valid_reg;
    logic                 p1_ok_reg;
    logic [6:0]           p1_count_reg;
    logic                 p2_ok_reg;
    logic [6:0]           p2_count_reg;
    pie_list_pkg::out_t   out_reg;

    logic                 accept;
    logic                 ok;
    pie_list_pkg::kind_t  kind;
    logic [IDX_W-1:0]     idx;
    logic [CMP_W-1:0]     pos_c;
    logic [CMP_W-1:0]     fill_c;
    logic [WORD_BITS-1:0] word_st;

    logic [WORD_BITS-1:0] value [CAPACITY];
    logic [WORD_BITS-1:0] sel   [CAPACITY];
    logic [WORD_BITS-1:0] grp   [NG];
    logic [WORD_BITS-1:0] rd_word;

    assign in_ready = !p1_valid_reg && !p2_valid_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign pos_c   = CMP_W'(in_data.position);
    assign fill_c  = CMP_W'(fill_reg);
    assign word_st = WORD_BITS'($unsigned(in_data.word_in));

    always_comb
    begin
        ok        = 1'b0;
        kind      = pie_list_pkg::K_NONE;
        idx       = IDX_W'(pos_c);
        fill_next = fill_reg;
        if (accept)
        begin
            unique case (in_data.op)
                pie_list_pkg::OP_READ:
                begin
                    if (pos_c < fill_c)
                    begin
                        ok   = 1'b1;
                        kind = pie_list_pkg::K_READ;
                    end
                end
                pie_list_pkg::OP_WRITE:
                begin
                    if (pos_c < fill_c)
                    begin
                        ok   = 1'b1;
                        kind = pie_list_pkg::K_LOAD;
                    end
                end
                pie_list_pkg::OP_APPEND:
                begin
                    if (fill_c < CAP_C)
                    begin
                        ok        = 1'b1;
                        kind      = pie_list_pkg::K_LOAD;
                        idx       = IDX_W'(fill_c);
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                pie_list_pkg::OP_INSERT:
                begin
                    if (fill_c < CAP_C && pos_c <= fill_c)
                    begin
                        ok        = 1'b1;
                        kind      = pie_list_pkg::K_INSERT;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                pie_list_pkg::OP_ERASE:
                begin
                    if (pos_c < fill_c)
                    begin
                        ok        = 1'b1;
                        kind      = pie_list_pkg::K_ERASE;
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = value[i+1];
        end

        pie_list_cell #(
            .CAPACITY  (CAPACITY),
            .WORD_BITS (WORD_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk   (clk),
            .kind  (kind),
            .idx   (idx),
            .word  (word_st),
            .left  (left_w),
            .right (right_w),
            .value (value[i]),
            .sel   (sel[i])
        );
    end

    pie_list_or_tree #(
        .N (CAPACITY),
        .W (WORD_BITS),
        .G (pie_list_pkg::OR_GROUP)
    ) u_or_tree (
        .clk  (clk),
        .leaf (sel),
        .grp  (grp)
    );

    always_comb
    begin
        rd_word = '0;
        for (int g = 0; g < NG; g++)
        begin
            rd_word = rd_word | grp[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            if (p2_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_ok_reg    <= ok;
            p1_count_reg <= 7'(fill_next);
        end
        if (p1_valid_reg)
        begin
            p2_ok_reg    <= p1_ok_reg;
            p2_count_reg <= p1_count_reg;
        end
        if (p2_valid_reg)
        begin
            out_reg.ok       <= p2_ok_reg;
            out_reg.word_out <= $signed(32'(rd_word));
            out_reg.count    <= p2_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= CAPACITY)
        else $error("count beyond capacity");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(p1_valid_reg && p2_valid_reg))
        else $error("two requests in flight");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> !out_valid_reg)
        else $error("result would overwrite a waiting beat");

    a_fail_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ok) |=> $stable(fill_reg))
        else $error("failed request changed the count");

    a_fail_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.ok || out_reg.word_out == 32'sd0))
        else $error("failed request returned a word");

endmodule
